// ===== hdl/pse_pkg.sv =====
// Shared types and codes for the postfix stack evaluator.
package pse_pkg;

	localparam int unsigned DATA_W = 32;

	typedef logic [DATA_W-1:0] word_t;

	// Command codes on the kind field; codes above end are ignored
	typedef enum logic [2:0] {
		KIND_PUSH = 3'd0,
		KIND_ADD  = 3'd1,
		KIND_SUB  = 3'd2,
		KIND_MUL  = 3'd3,
		KIND_DIV  = 3'd4,
		KIND_END  = 3'd5
	} kind_t;

	// Status reported with each result item
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_UNDER   = 2'd1,
		STAT_OVER    = 2'd2,
		STAT_DIVZERO = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_DIV  = 2'd2
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		word_t quotient;
	} div_rsp_t;

endpackage

// ===== hdl/postfix_stack_evaluator_core.sv =====
// Postfix stack evaluator top level: command sequencer, top-of-stack register and result slot.
//
// Each input item is one postfix command on a signed 32-bit operand stack of
// STACK_DEPTH entries. The top of the stack lives in a register and the
// entries below it in a synchronous RAM with one read and one write port, so
// add, subtract and multiply run as a RAM read for the left operand, then the
// operation, and divide as a RAM read, divider load, 32 radix-2 steps and a
// quotient writeback; the iterative divider sets the worst-case rate, and no
// command is taken until an operation finishes. A result item is produced only
// by an end command; it waits in an output register, and commands other than
// end are still taken while it waits. An error (underflow, overflow, divide by
// zero) freezes the stack until the next end, which reports it with a zero
// result. The stack RAM needs no initialization after reset.
module postfix_stack_evaluator_core #(
	parameter int unsigned STACK_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result,
	output logic [1:0]         status
);
	import pse_pkg::*;

	localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
	localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	status_t          err_q;
	word_t            tos_q;
	kind_t            op_q;
	logic             out_valid_q;
	word_t            result_q;
	status_t          status_q;

	logic             in_acc;
	logic             is_end;
	logic             is_push;
	logic             is_op;
	logic             slot_free;
	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic             rd_en;
	logic [ADDR_W-1:0] rd_addr;
	word_t            rd_data;
	word_t            mul_lo;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	// Command decode
	assign is_end    = kind == KIND_END;
	assign is_push   = kind == KIND_PUSH;
	assign is_op     = (kind == KIND_ADD) || (kind == KIND_SUB) ||
	                   (kind == KIND_MUL) || (kind == KIND_DIV);
	assign slot_free = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;

	// Stack below the top entry
	pse_stack_ram #(
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(tos_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pse_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign mul_lo = rd_data * tos_q;

	// Handshake, RAM and divider controls
	always_comb begin
		in_ready = (state_q == ST_IDLE) && (slot_free || !is_end);
		// push spills the old top into the RAM
		wr_en   = in_acc && is_push && (err_q == STAT_OK) &&
		          (count_q < DEPTH_C) && (count_q != '0);
		wr_addr = ADDR_W'(count_q - ONE_C);
		// operation fetches the left operand
		rd_en   = in_acc && is_op && (err_q == STAT_OK) && (count_q >= TWO_C);
		rd_addr = ADDR_W'(count_q - TWO_C);
		div_req.start    = (state_q == ST_EXEC) && (op_q == KIND_DIV) && (tos_q != '0);
		div_req.dividend = rd_data;
		div_req.divisor  = tos_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (rd_en) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = div_req.start ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (div_rsp.done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stack count, error and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && is_end) begin
				count_q <= '0;
				err_q   <= STAT_OK;
			end else if (in_acc && is_push && err_q == STAT_OK) begin
				if (count_q >= DEPTH_C) begin
					err_q <= STAT_OVER;
				end else begin
					count_q <= count_q + ONE_C;
				end
			end else if (in_acc && is_op && err_q == STAT_OK && count_q < TWO_C) begin
				err_q <= STAT_UNDER;
			end
			if (state_q == ST_EXEC) begin
				if (op_q != KIND_DIV) begin
					count_q <= count_q - ONE_C;
				end else if (tos_q == '0) begin
					err_q <= STAT_DIVZERO;
				end
			end
			if (state_q == ST_DIV && div_rsp.done) begin
				count_q <= count_q - ONE_C;
			end
			if (in_acc && is_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Top of stack, pending operation and result payload
	always_ff @(posedge clk) begin
		if (in_acc && is_end) begin
			result_q <= (err_q == STAT_OK && count_q != '0) ? tos_q : '0;
			if (err_q != STAT_OK) begin
				status_q <= err_q;
			end else begin
				status_q <= (count_q == '0) ? STAT_UNDER : STAT_OK;
			end
		end
		if (in_acc && is_push && err_q == STAT_OK && count_q < DEPTH_C) begin
			tos_q <= operand;
		end
		if (rd_en) begin
			op_q <= kind_t'(kind);
		end
		if (state_q == ST_EXEC) begin
			case (op_q)
				KIND_ADD: tos_q <= rd_data + tos_q;
				KIND_SUB: tos_q <= rd_data - tos_q;
				KIND_MUL: tos_q <= mul_lo;
				default:  tos_q <= tos_q;
			endcase
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			tos_q <= div_rsp.quotient;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign status    = status_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count above depth");

	a_exec_operands: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> count_q >= TWO_C)
		else $error("operation running with fewer than two operands");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_end |=> out_valid_q && count_q == '0 && err_q == STAT_OK)
		else $error("end did not post a result and clear the stack");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_rsp.busy)
		else $error("waiting on an idle divider");

endmodule

// ===== hdl/pse_stack_ram.sv =====
// Operand stack storage: one write port, one registered read port.
module pse_stack_ram #(
	parameter int unsigned DEPTH = 128,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  pse_pkg::word_t     wr_data,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output pse_pkg::word_t     rd_data
);
	import pse_pkg::*;

	word_t mem_q [DEPTH];
	word_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/pse_divider.sv =====
// Radix-2 restoring signed divider, quotient truncated toward zero.
module pse_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  pse_pkg::div_req_t req,
	output pse_pkg::div_rsp_t rsp
);
	import pse_pkg::*;

	localparam int unsigned STEPS = DATA_W;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);
	localparam logic [CNT_W-1:0] STEPS_C = CNT_W'(STEPS);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            rem_q;
	word_t            quo_q;
	word_t            div_q;
	logic             neg_q;

	logic [DATA_W:0]  rem_sh;
	logic [DATA_W:0]  rem_diff;
	logic             ge;
	word_t            dvd_abs;
	word_t            dvs_abs;

	// Magnitudes of the operands
	assign dvd_abs = req.dividend[DATA_W-1] ? word_t'(-req.dividend) : req.dividend;
	assign dvs_abs = req.divisor[DATA_W-1] ? word_t'(-req.divisor) : req.divisor;

	// One quotient bit per step
	assign rem_sh   = {rem_q, quo_q[DATA_W-1]};
	assign ge       = rem_sh >= {1'b0, div_q};
	assign rem_diff = rem_sh - {1'b0, div_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEPS_C;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= dvd_abs;
			div_q <= dvs_abs;
			neg_q <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = busy_q && (cnt_q == '0);
	assign rsp.quotient = neg_q ? word_t'(-quo_q) : quo_q;

endmodule
